FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the keyword token classifier.
// Depends on nothing; each macro takes its clock and active-low reset as arguments.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that, once seen, forces another one on the following edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ktc_pkg.sv
// Types and constant tables for the keyword token classifier.
// Depends on nothing; used by ktc_match and keyword_token_classifier.
package ktc_pkg;

    localparam int LANES        = 16;
    localparam int WORD_W       = 8 * LANES;
    localparam int LEN_W        = 5;
    localparam int IDX_W        = 6;
    localparam int NUM_KEYWORDS = 36;
    localparam int NUM_HEADERS  = 2;

    typedef enum logic [2:0] {
        KIND_OPERATOR = 3'd0,
        KIND_SPECIAL  = 3'd1,
        KIND_NUMBER   = 3'd2,
        KIND_KEYWORD  = 3'd3,
        KIND_HEADER   = 3'd4,
        KIND_IDENT    = 3'd5
    } kind_t;

    typedef struct packed {
        logic             hit_keyword;
        logic             hit_header;
        logic [IDX_W-1:0] index;
    } match_t;

    // A string literal is right-justified with its last character in the low byte.
    // This puts the first character in the low byte instead, zero-padded above.
    function automatic logic [WORD_W-1:0] lsb_first(input logic [WORD_W-1:0] s);
        logic [WORD_W-1:0] r;
        int                n;
        r = '0;
        n = 0;
        for (int i = 0; i < LANES; i++)
        begin
            if (s[8*i +: 8] != 8'h00)
            begin
                n = i + 1;
            end
        end
        for (int i = 0; i < LANES; i++)
        begin
            if (i < n)
            begin
                r[8*i +: 8] = s[8*(n-1-i) +: 8];
            end
        end
        return r;
    endfunction

    localparam logic [WORD_W-1:0] KW_WORDS [NUM_KEYWORDS] = '{
        lsb_first("auto"),     lsb_first("using"),    lsb_first("namespace"),
        lsb_first("include"),  lsb_first("break"),    lsb_first("case"),
        lsb_first("char"),     lsb_first("const"),    lsb_first("continue"),
        lsb_first("default"),  lsb_first("do"),       lsb_first("double"),
        lsb_first("else"),     lsb_first("enum"),     lsb_first("extern"),
        lsb_first("float"),    lsb_first("for"),      lsb_first("goto"),
        lsb_first("if"),       lsb_first("int"),      lsb_first("long"),
        lsb_first("public"),   lsb_first("register"), lsb_first("return"),
        lsb_first("short"),    lsb_first("signed"),   lsb_first("sizeof"),
        lsb_first("static"),   lsb_first("struct"),   lsb_first("switch"),
        lsb_first("typedef"),  lsb_first("union"),    lsb_first("unsigned"),
        lsb_first("void"),     lsb_first("volatile"), lsb_first("while")
    };

    localparam logic [WORD_W-1:0] HDR_WORDS [NUM_HEADERS] = '{
        lsb_first("iostream"), lsb_first("stdio")
    };

endpackage

FILE: rtl/ktc_match.sv
// Looks a held word up in the keyword and header tables, all entries at once.
// Depends on ktc_pkg for the tables and the match_t result type.
module ktc_match (
    input  logic [ktc_pkg::WORD_W-1:0] word,
    output ktc_pkg::match_t            result
);

    // Bytes beyond the word's length arrive as zero and word characters are never
    // zero, so a full-width compare also checks the length.
    always_comb
    begin
        result = '0;
        for (int k = 0; k < ktc_pkg::NUM_KEYWORDS; k++)
        begin
            if (word == ktc_pkg::KW_WORDS[k])
            begin
                result.hit_keyword = 1'b1;
                result.index       = ktc_pkg::IDX_W'(k);
            end
        end
        if (!result.hit_keyword)
        begin
            for (int k = 0; k < ktc_pkg::NUM_HEADERS; k++)
            begin
                if (word == ktc_pkg::HDR_WORDS[k])
                begin
                    result.hit_header = 1'b1;
                    result.index      = ktc_pkg::IDX_W'(k);
                end
            end
        end
    end

endmodule

FILE: rtl/keyword_token_classifier.sv
// Keyword token classifier: one source character per beat, at most one token out.
// A token appears in the cycle after the character beat that causes it.
// Throughput: one character per cycle unless stalled; lookup is a combinational parallel compare.
// The output register frees itself in the cycle its beat is taken, so input stalls only
// while a token waits. Reset (rst_n, asynchronous) empties the word and the output.
// Depends on ktc_pkg, ktc_match and assert_macros.svh.
`include "assert_macros.svh"

module keyword_token_classifier #(
    parameter int MAX_WORD = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_ready,
    input  logic [7:0]  character,
    output logic        token_valid,
    input  logic        token_ready,
    output logic [2:0]  kind,
    output logic [7:0]  symbol,
    output logic [4:0]  word_length,
    output logic [63:0] word_first_eight,
    output logic [63:0] word_last_eight,
    output logic [5:0]  table_index,
    output logic        word_truncated
);

    localparam int CW = $clog2(MAX_WORD + 1);
    localparam int IW = $clog2(MAX_WORD);

    logic [7:0]    chars_reg [MAX_WORD];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          overflow_reg;
    logic          overflow_next;

    logic                         token_valid_reg;
    ktc_pkg::kind_t               kind_reg;
    logic [7:0]                   symbol_reg;
    logic [ktc_pkg::LEN_W-1:0]    length_reg;
    logic [ktc_pkg::WORD_W-1:0]   word_reg;
    logic [ktc_pkg::IDX_W-1:0]    index_reg;
    logic                         truncated_reg;

    logic                         accept;
    logic                         is_op;
    logic                         is_sp;
    logic                         is_digit;
    logic                         is_alpha;
    logic                         is_sep;
    logic                         emit_char;
    logic                         emit_word;
    logic                         room;
    logic [7:0]                   lane [ktc_pkg::LANES];
    logic [ktc_pkg::WORD_W-1:0]   word;
    ktc_pkg::match_t              match;
    ktc_pkg::kind_t               word_kind;

    assign char_ready = !token_valid_reg || token_ready;
    assign accept     = char_valid && char_ready;

    always_comb
    begin
        is_op = 1'b0;
        is_sp = 1'b0;
        case (character)
            "+", "-", "*", "/", "%", "=", "<", ">":
            begin
                is_op = 1'b1;
            end
            "#", ";", ",", ".", "{", "}", "[", "]", "(", ")":
            begin
                is_sp = 1'b1;
            end
            default:
            begin
                is_op = 1'b0;
                is_sp = 1'b0;
            end
        endcase
    end

    assign is_digit  = (character >= "0") && (character <= "9");
    assign is_alpha  = ((character >= "A") && (character <= "Z"))
                    || ((character >= "a") && (character <= "z"));
    assign is_sep    = (character == " ") || (character == 8'h0A);
    assign emit_char = is_op || is_sp || is_digit;
    assign emit_word = is_sep && (count_reg != '0);
    assign room      = count_reg < CW'(MAX_WORD);

    // Lanes at or past the fill count read as zero, as do lanes the buffer lacks.
    for (genvar i = 0; i < ktc_pkg::LANES; i++)
    begin : g_lane
        if (i < MAX_WORD)
        begin : g_held
            assign lane[i] = (CW'(i) < count_reg) ? chars_reg[i] : 8'h00;
        end
        else
        begin : g_absent
            assign lane[i] = 8'h00;
        end
        assign word[8*i +: 8] = lane[i];
    end

    ktc_match u_match (
        .word   (word),
        .result (match)
    );

    always_comb
    begin
        if (match.hit_keyword)
        begin
            word_kind = ktc_pkg::KIND_KEYWORD;
        end
        else if (match.hit_header)
        begin
            word_kind = ktc_pkg::KIND_HEADER;
        end
        else
        begin
            word_kind = ktc_pkg::KIND_IDENT;
        end
    end

    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        if (is_digit || is_alpha)
        begin
            if (room)
            begin
                count_next = count_reg + CW'(1);
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end
        else if (emit_word)
        begin
            count_next    = '0;
            overflow_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else if (accept)
        begin
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (is_digit || is_alpha) && room)
        begin
            chars_reg[count_reg[IW-1:0]] <= character;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_valid_reg <= 1'b0;
        end
        else if (accept && (emit_char || emit_word))
        begin
            token_valid_reg <= 1'b1;
        end
        else if (token_ready)
        begin
            token_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit_char)
        begin
            kind_reg      <= is_op ? ktc_pkg::KIND_OPERATOR
                           : (is_sp ? ktc_pkg::KIND_SPECIAL : ktc_pkg::KIND_NUMBER);
            symbol_reg    <= character;
            length_reg    <= '0;
            word_reg      <= '0;
            index_reg     <= '0;
            truncated_reg <= 1'b0;
        end
        else if (accept && emit_word)
        begin
            kind_reg      <= word_kind;
            symbol_reg    <= 8'h00;
            length_reg    <= ktc_pkg::LEN_W'(count_reg);
            word_reg      <= word;
            index_reg     <= match.index;
            truncated_reg <= overflow_reg;
        end
    end

    assign token_valid      = token_valid_reg;
    assign kind             = kind_reg;
    assign symbol           = symbol_reg;
    assign word_length      = length_reg;
    assign word_first_eight = word_reg[63:0];
    assign word_last_eight  = word_reg[127:64];
    assign table_index      = index_reg;
    assign word_truncated   = truncated_reg;

    `ASSERT_ALWAYS(a_count_bounded, clk, rst_n, count_reg <= CW'(MAX_WORD), "word count past buffer depth")
    `ASSERT_ALWAYS(a_overflow_full, clk, rst_n, !overflow_reg || (count_reg == CW'(MAX_WORD)), "truncation flagged on a buffer that is not full")
    `ASSERT_NEXT(a_word_end, clk, rst_n, accept && emit_word, token_valid_reg && (count_reg == '0) && !overflow_reg, "word end did not empty the buffer and raise a token")
    `ASSERT_ALWAYS(a_word_len, clk, rst_n, !token_valid_reg || (kind_reg == ktc_pkg::KIND_OPERATOR) || (kind_reg == ktc_pkg::KIND_SPECIAL) || (kind_reg == ktc_pkg::KIND_NUMBER) || (length_reg != '0), "word token with zero length")

endmodule
